// ----- sv/orf_pkg.sv -----
// Shared constants and types for the overwriting ring FIFO with peek.
`timescale 1ns / 1ps
package orf_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] MODE_PUT  = 2'd0;
  localparam logic [1:0] MODE_GET  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  // Per-transfer controls from the pointer logic to the entry memory.
  typedef struct packed {
    logic load;
    logic wr_en;
    logic rd_en;
  } orf_mem_ctl_t;

  // Status half of the result register.
  typedef struct packed {
    logic [4:0] count_after;
    logic       is_empty;
    logic       is_full;
    logic       dropped_oldest;
    logic       op_error;
  } orf_status_t;

endpackage

// ----- sv/orf_ram.sv -----
// Entry memory with one write port and one registered read port.
`timescale 1ns / 1ps
module orf_ram
  import orf_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = DATA_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  orf_mem_ctl_t     ctl,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // The read register is the data half of the result register, so it
  // holds while the receiver stalls and reads zero for puts and errors.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rdata <= ctl.rd_en ? mem[raddr] : '0;
    end
  end

endmodule

// ----- sv/orf_ctrl.sv -----
// Oldest index, entry count, address generation and the status register.
`timescale 1ns / 1ps
module orf_ctrl
  import orf_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    mode,
  input  logic [3:0]    offset,
  output orf_mem_ctl_t  mem_ctl,
  output logic [AW-1:0] waddr,
  output logic [AW-1:0] raddr,
  output orf_status_t   status
);

  // Sum width for ring additions: holds any sum below twice the capacity, and the offset.
  localparam int SW = (AW + 1 > 5) ? AW + 1 : 5;
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [AW-1:0] oldest, oldest_next;
  logic [CW-1:0] count, count_next;
  logic          full;
  logic          dropped, error;
  logic          wr_en, rd_en;
  logic [SW-1:0] sum_tail, sum_peek, sum_inc;
  logic [AW-1:0] tail_addr, peek_addr, inc_addr;
  logic [CW+4:0] count_wide;

  assign full = (count == CAP_C);

  // Each sum that addresses the memory stays below twice the capacity, so one subtract wraps it.
  always_comb begin
    sum_tail  = SW'(oldest) + SW'(count);
    sum_peek  = SW'(oldest) + SW'(offset);
    sum_inc   = SW'(oldest) + SW'(1);
    tail_addr = AW'((sum_tail >= CAP_S) ? sum_tail - CAP_S : sum_tail);
    peek_addr = AW'((sum_peek >= CAP_S) ? sum_peek - CAP_S : sum_peek);
    inc_addr  = AW'((sum_inc  >= CAP_S) ? sum_inc  - CAP_S : sum_inc);
  end

  always_comb begin
    oldest_next = oldest;
    count_next  = count;
    dropped     = 1'b0;
    error       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    waddr       = tail_addr;
    raddr       = oldest;
    case (mode)
      MODE_PUT: begin
        wr_en = 1'b1;
        if (full) begin
          // The new word lands in the slot of the entry it displaces.
          waddr       = oldest;
          oldest_next = inc_addr;
          dropped     = 1'b1;
        end else begin
          count_next = count + CW'(1);
        end
      end
      MODE_GET: begin
        if (count == '0) begin
          error = 1'b1;
        end else begin
          rd_en       = 1'b1;
          oldest_next = inc_addr;
          count_next  = count - CW'(1);
        end
      end
      MODE_PEEK: begin
        if (SW'(offset) >= SW'(count)) begin
          error = 1'b1;
        end else begin
          rd_en = 1'b1;
          raddr = peek_addr;
        end
      end
      default: begin
        error = 1'b1;
      end
    endcase
  end

  assign mem_ctl.load  = accept;
  assign mem_ctl.wr_en = accept & wr_en;
  assign mem_ctl.rd_en = rd_en;

  assign count_wide = (CW + 5)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
    end else if (accept) begin
      oldest <= oldest_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status.count_after    <= count_wide[4:0];
      status.is_empty       <= (count_next == '0);
      status.is_full        <= (count_next == CAP_C);
      status.dropped_oldest <= dropped;
      status.op_error       <= error;
    end
  end

endmodule

// ----- sv/overwriting_ring_fifo_with_peek.sv -----
// Top level of the overwriting ring FIFO with peek.
//
// The input channel carries one operation per transfer: mode selects put,
// get of the oldest word, or peek at offset entries past the oldest. Each
// accepted operation yields exactly one result transfer with the data word,
// the entry count after the operation, empty and full flags, a flag for a
// put that discarded the oldest entry, and an error flag for a get on an
// empty buffer, a peek past the count or an unknown mode.
//
// The result is registered: result valid rises in the cycle after the input
// transfer. Throughput is one operation per cycle while the receiver takes
// results, set by the entry memory's single write and registered read port.
//
// The result register decouples the two sides: outside reset, in_ready is
// high whenever the result register is empty or is being taken in the same
// cycle, so a stalled receiver holds the current result and back-pressures
// the input. Reset holds in_ready low and clears the oldest index, the count
// and the result valid bit; the stored words are not cleared, since only
// written entries are ever read.
`timescale 1ns / 1ps
module overwriting_ring_fifo_with_peek
  import orf_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] data_in,
  input  logic [3:0]  offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] data_out,
  output logic [4:0]  count_after,
  output logic        is_empty,
  output logic        is_full,
  output logic        dropped_oldest,
  output logic        op_error
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  accept;
  orf_mem_ctl_t          mem_ctl;
  logic [AW-1:0]         waddr, raddr;
  orf_status_t           status;
  logic [DATA_WIDTH+31:0] din_wide, dout_wide;
  logic [DATA_WIDTH-1:0] rdata;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  orf_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .mode    (mode),
    .offset  (offset),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .raddr   (raddr),
    .status  (status)
  );

  assign din_wide = (DATA_WIDTH + 32)'(data_in);

  orf_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (din_wide[DATA_WIDTH-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign dout_wide      = (DATA_WIDTH + 32)'(rdata);
  assign data_out       = dout_wide[31:0];
  assign count_after    = status.count_after;
  assign is_empty       = status.is_empty;
  assign is_full        = status.is_full;
  assign dropped_oldest = status.dropped_oldest;
  assign op_error       = status.op_error;

endmodule

// ----- sv/orf_checker.sv -----
// Port-level checks for the overwriting ring FIFO with peek, and its bind.
`timescale 1ns / 1ps
module orf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] data_out,
  input logic [4:0]  count_after,
  input logic        is_empty,
  input logic        is_full,
  input logic        dropped_oldest,
  input logic        op_error
);

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(count_after))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> count_after == 5'd0 && !is_full)
    else $error("empty flag disagrees with count");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && op_error |-> data_out == 32'd0 && !dropped_oldest)
    else $error("failed operation returned data or dropped an entry");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped_oldest |-> is_full && !is_empty && !op_error)
    else $error("discard reported while not full");

endmodule

bind overwriting_ring_fifo_with_peek orf_checker u_orf_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .data_out       (data_out),
  .count_after    (count_after),
  .is_empty       (is_empty),
  .is_full        (is_full),
  .dropped_oldest (dropped_oldest),
  .op_error       (op_error)
);
